>>> rtl/core/section_latency_statistics_core_defines.svh
// Assertion helpers for the latency statistics core.
`ifndef SECTION_LATENCY_STATISTICS_CORE_DEFINES_SVH
`define SECTION_LATENCY_STATISTICS_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/slstat_pkg.sv
package slstat_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int DIV_W      = 36;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int LIMIT_W    = 22;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [11:0] PERIOD_RESET = 12'd10;
  localparam logic [9:0]  MS_PER_S     = 10'd1000;

  typedef struct packed {
    logic load;
    logic close_step;
    logic idx_clr;
    logic idx_inc;
    logic div_start;
    logic div_share;
    logic out_load;
    logic clear_all;
  } slstat_cmd_t;

  typedef struct packed {
    logic is_close;
    logic idx_last;
    logic due;
    logic div_done;
  } slstat_sts_t;

endpackage

>>> rtl/core/slstat_if.sv
interface slstat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  slot;
  logic [31:0] now_us;
  logic [31:0] now_ms;
  modport source (output valid, mode, slot, now_us, now_ms, input ready);
  modport sink (input valid, mode, slot, now_us, now_ms, output ready);
endinterface

interface slstat_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  report_slot;
  logic [31:0] average_us;
  logic [31:0] minimum_us;
  logic [31:0] maximum_us;
  logic [31:0] total_us;
  logic [15:0] share_hundredths;
  logic [31:0] period_ms;
  logic [31:0] sample_count;
  logic        last_line;
  modport source (output valid, report_slot, average_us, minimum_us, maximum_us,
                  total_us, share_hundredths, period_ms, sample_count, last_line,
                  input ready);
  modport sink (input valid, report_slot, average_us, minimum_us, maximum_us,
                total_us, share_hundredths, period_ms, sample_count, last_line,
                output ready);
endinterface

interface slstat_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] report_period_seconds;
  modport source (output valid, report_period_seconds, input ready);
  modport sink (input valid, report_period_seconds, output ready);
endinterface

>>> rtl/core/slstat_ctrl.sv
`include "section_latency_statistics_core_defines.svh"

module slstat_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  slstat_pkg::slstat_sts_t   sts,
  output slstat_pkg::slstat_cmd_t   cmd
);
  import slstat_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLOSE  = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_AVG_GO = 9'b000001000,
    S_AVG    = 9'b000010000,
    S_SHR_GO = 9'b000100000,
    S_SHR    = 9'b001000000,
    S_EMIT   = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.is_close) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        cmd.close_step = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DECIDE: state_nxt = sts.due ? S_AVG_GO : S_IDLE;
      S_AVG_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_AVG;
      end
      S_AVG: if (sts.div_done) state_nxt = S_SHR_GO;
      S_SHR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_share = 1'b1;
        state_nxt     = S_SHR;
      end
      S_SHR: if (sts.div_done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid_r) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_AVG_GO;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r) begin
          cmd.clear_all = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SLS_ASSERT_NOW(a_idle_out_empty, clk, rst_n, in_ready, !out_valid_r, "word pending in idle")
  `SLS_ASSERT_NOW(a_load_free, clk, rst_n, cmd.out_load, !out_valid_r, "output overwritten")
  `SLS_ASSERT_NEXT(a_close_walk, clk, rst_n, in_valid && in_ready && sts.is_close,
                   state_r == S_CLOSE, "close pass not started")

endmodule

>>> rtl/core/slstat_dp.sv
`include "section_latency_statistics_core_defines.svh"

module slstat_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               in_mode,
  input  logic [3:0]               in_slot,
  input  logic [31:0]              in_now_us,
  input  logic [31:0]              in_now_ms,
  input  logic                     cfg_we,
  input  logic [11:0]              cfg_period,
  input  slstat_pkg::slstat_cmd_t  cmd,
  output slstat_pkg::slstat_sts_t  sts,
  output logic [3:0]               out_report_slot,
  output logic [31:0]              out_average_us,
  output logic [31:0]              out_minimum_us,
  output logic [31:0]              out_maximum_us,
  output logic [31:0]              out_total_us,
  output logic [15:0]              out_share_hundredths,
  output logic [31:0]              out_period_ms,
  output logic [31:0]              out_sample_count,
  output logic                     out_last_line
);
  import slstat_pkg::*;

  logic [31:0] start_r [SLOT_COUNT];
  logic [31:0] end_r   [SLOT_COUNT];
  logic [31:0] min_r   [SLOT_COUNT];
  logic [31:0] max_r   [SLOT_COUNT];
  logic [31:0] sum_r   [SLOT_COUNT];
  logic [31:0] cnt_r   [SLOT_COUNT];

  logic [11:0]        period_r;
  logic [31:0]        last_ms_r;
  logic [31:0]        now_ms_r;
  logic [SLOT_W-1:0]  idx_r;

  logic [DIV_W-1:0]     dvd_r;
  logic [31:0]          dvs_r;
  logic [31:0]          rem_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 div_shr_r;
  logic [31:0]          avg_r;

  logic [31:0]        cur_s, cur_e, cur_d, cur_sum, cur_cnt, elapsed;
  logic [LIMIT_W-1:0] limit;
  logic [32:0]        rem_sh;
  logic               ge;
  logic [DIV_W-1:0]   sum_ext;
  logic               mark_ok;
  logic [SLOT_W-1:0]  mark_idx;

  assign cur_s    = start_r[idx_r];
  assign cur_e    = end_r[idx_r];
  assign cur_d    = cur_e - cur_s;
  assign cur_sum  = sum_r[idx_r];
  assign cur_cnt  = cnt_r[idx_r];
  assign elapsed  = now_ms_r - last_ms_r;
  assign limit    = LIMIT_W'(period_r) * LIMIT_W'(MS_PER_S);
  assign sum_ext  = DIV_W'(cur_sum);
  assign rem_sh   = {rem_r, dvd_r[DIV_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs_r};
  assign mark_ok  = (int'(in_slot) < SLOT_COUNT) &&
                    ((in_mode == MODE_START) || (in_mode == MODE_END));
  assign mark_idx = SLOT_W'(in_slot);

  assign sts.is_close = (in_mode == MODE_CLOSE);
  assign sts.idx_last = (idx_r == SLOT_W'(SLOT_COUNT - 1));
  assign sts.due      = elapsed > 32'(limit);
  assign sts.div_done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
        min_r[i]   <= '1;
        max_r[i]   <= '0;
        sum_r[i]   <= '0;
        cnt_r[i]   <= '0;
      end
      last_ms_r <= '0;
      period_r  <= PERIOD_RESET;
    end else begin
      if (cfg_we) period_r <= cfg_period;
      if (cmd.load && mark_ok) begin
        if (in_mode == MODE_START) start_r[mark_idx] <= in_now_us;
        else end_r[mark_idx] <= in_now_us;
      end
      if (cmd.close_step && !(cur_s == '0 && cur_e == '0)) begin
        if (cur_d < min_r[idx_r]) min_r[idx_r] <= cur_d;
        if (cur_d > max_r[idx_r]) max_r[idx_r] <= cur_d;
        sum_r[idx_r]   <= cur_sum + cur_d;
        cnt_r[idx_r]   <= cur_cnt + 32'd1;
        start_r[idx_r] <= '0;
        end_r[idx_r]   <= '0;
      end
      if (cmd.clear_all) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          start_r[i] <= '0;
          end_r[i]   <= '0;
          min_r[i]   <= '1;
          max_r[i]   <= '0;
          sum_r[i]   <= '0;
          cnt_r[i]   <= '0;
        end
        last_ms_r <= now_ms_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + SLOT_W'(1);
      if (cmd.div_start) begin
        busy_r <= 1'b1;
        dcnt_r <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        dcnt_r <= dcnt_r - DIV_CNT_W'(1);
        if (dcnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) now_ms_r <= in_now_ms;
    if (cmd.div_start) begin
      rem_r     <= '0;
      div_shr_r <= cmd.div_share;
      if (cmd.div_share) begin
        dvd_r <= (sum_ext << 3) + (sum_ext << 1);
        dvs_r <= elapsed;
      end else begin
        dvd_r <= sum_ext;
        dvs_r <= (cur_cnt == '0) ? 32'd1 : cur_cnt;
      end
    end else if (busy_r) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, dvs_r}) : rem_sh[31:0];
      dvd_r <= {dvd_r[DIV_W-2:0], ge};
    end
    if (done_r && !div_shr_r) avg_r <= dvd_r[31:0];
    if (cmd.out_load) begin
      out_report_slot      <= 4'(idx_r);
      out_average_us       <= avg_r;
      out_minimum_us       <= min_r[idx_r];
      out_maximum_us       <= max_r[idx_r];
      out_total_us         <= cur_sum;
      out_share_hundredths <= (|dvd_r[DIV_W-1:16]) ? 16'hFFFF : dvd_r[15:0];
      out_period_ms        <= elapsed;
      out_sample_count     <= cur_cnt;
      out_last_line        <= sts.idx_last;
    end
  end

  `SLS_ASSERT_NEXT(a_div_busy, clk, rst_n, cmd.div_start, busy_r, "divider not started")
  `SLS_ASSERT_NOW(a_done_idle, clk, rst_n, done_r, !busy_r, "divider done while busy")
  `SLS_ASSERT_NOW(a_start_free, clk, rst_n, cmd.div_start, !busy_r, "divider restarted")

endmodule

>>> rtl/core/section_latency_statistics_core.sv
// A start or end mark is taken in S_IDLE; a close step walks all slots in S_CLOSE, then goes to S_DECIDE.
// When a report is due, each slot takes two 36-step passes of the shared radix-2 divider
// (average, then share), plus the output word handoff; the slots are then cleared in S_FIN.
// One input word is taken at a time; in_ready is high only between items.
// Reset (rst_n low, synchronous): stamps, maximum, sum and count cleared, minimum all ones,
// last report time 0, report period 10 s. No clearing pass is needed.
module section_latency_statistics_core (
  input  logic          clk,
  input  logic          rst_n,
  slstat_in_if.sink     in_ch,
  slstat_out_if.source  out_ch,
  slstat_cfg_if.sink    cfg_ch
);
  import slstat_pkg::*;

  slstat_cmd_t cmd;
  slstat_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  slstat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slstat_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_mode              (in_ch.mode),
    .in_slot              (in_ch.slot),
    .in_now_us            (in_ch.now_us),
    .in_now_ms            (in_ch.now_ms),
    .cfg_we               (cfg_ch.valid),
    .cfg_period           (cfg_ch.report_period_seconds),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_report_slot      (out_ch.report_slot),
    .out_average_us       (out_ch.average_us),
    .out_minimum_us       (out_ch.minimum_us),
    .out_maximum_us       (out_ch.maximum_us),
    .out_total_us         (out_ch.total_us),
    .out_share_hundredths (out_ch.share_hundredths),
    .out_period_ms        (out_ch.period_ms),
    .out_sample_count     (out_ch.sample_count),
    .out_last_line        (out_ch.last_line)
  );

endmodule
